FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file csa_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication that must hold at the same clock edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

FILE: hdl/csa_pkg.sv
// Types and constants for the cosine similarity accumulator.
// No dependencies.
package csa_pkg;

    localparam int EnergyW = 47;
    localparam int DotW    = 48;
    localparam int ProdPW  = 2 * EnergyW;
    localparam int ProdSW  = 2 * DotW;
    localparam int RemW    = ProdSW + 32;
    localparam int QuotW   = 34;
    localparam int MagW    = 17;

    localparam logic [EnergyW-1:0] EnergyMax = {EnergyW{1'b1}};
    localparam logic [MagW-1:0]    MagOne    = 17'd32768;

    typedef struct packed {
        logic [EnergyW-1:0]     e1;
        logic [EnergyW-1:0]     e2;
        logic signed [DotW-1:0] dot;
    } csa_entry_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_SQRT = 5'b01000,
        ST_FIN  = 5'b10000
    } csa_state_t;

endpackage

FILE: hdl/csa_queue.sv
// Two-entry queue of finished accumulator sets between front and back.
// Depends on csa_pkg.
module csa_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  csa_pkg::csa_entry_t push_data,
    input  logic                pop,
    output csa_pkg::csa_entry_t pop_data,
    output logic                full,
    output logic                empty
);
    import csa_pkg::*;

    csa_entry_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule

FILE: hdl/csa_front.sv
// Front end: takes one pair per item, accumulates energies and dot product.
// Depends on csa_pkg; pushes finished sets into csa_queue.
module csa_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                q_full,
    input  logic signed [15:0]  first_value,
    input  logic signed [15:0]  second_value,
    input  logic                last_pair,
    output logic                push,
    output csa_pkg::csa_entry_t push_data
);
    import csa_pkg::*;

    logic [EnergyW-1:0]     e1_reg, e2_reg, e1_next, e2_next;
    logic signed [DotW-1:0] dot_reg, dot_next;
    logic signed [31:0]     aa, bb, ab;
    logic [EnergyW:0]       e1_sum, e2_sum;
    logic signed [DotW:0]   dot_sum;
    logic                   acc;

    assign aa = first_value * first_value;
    assign bb = second_value * second_value;
    assign ab = first_value * second_value;

    always_comb begin
        e1_sum  = {1'b0, e1_reg} + (EnergyW+1)'(unsigned'(aa));
        e2_sum  = {1'b0, e2_reg} + (EnergyW+1)'(unsigned'(bb));
        dot_sum = {dot_reg[DotW-1], dot_reg} + (DotW+1)'(ab);
        e1_next = e1_sum[EnergyW] ? EnergyMax : e1_sum[EnergyW-1:0];
        e2_next = e2_sum[EnergyW] ? EnergyMax : e2_sum[EnergyW-1:0];
        // clamp on signed overflow of the dot product
        if (dot_sum[DotW] != dot_sum[DotW-1])
        begin
            dot_next = dot_sum[DotW] ? {1'b1, {(DotW-1){1'b0}}} : {1'b0, {(DotW-1){1'b1}}};
        end
        else
        begin
            dot_next = dot_sum[DotW-1:0];
        end
    end

    assign acc            = in_valid && !q_full;
    assign push           = acc && last_pair;
    assign push_data.e1   = e1_next;
    assign push_data.e2   = e2_next;
    assign push_data.dot  = dot_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            e1_reg  <= '0;
            e2_reg  <= '0;
            dot_reg <= '0;
        end
        else if (acc)
        begin
            // restart the sums after the last pair
            e1_reg  <= last_pair ? '0 : e1_next;
            e2_reg  <= last_pair ? '0 : e2_next;
            dot_reg <= last_pair ? '0 : dot_next;
        end
    end
endmodule

FILE: hdl/csa_back.sv
// Back end: multiplies, divides and takes the root to form the cosine.
// Depends on csa_pkg; pops sets from csa_queue, drives the result register.
module csa_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  csa_pkg::csa_entry_t q_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  cosine,
    output logic                degenerate
);
    import csa_pkg::*;

    csa_state_t          state_reg;
    logic [5:0]          cnt_reg;
    logic                neg_reg;
    logic [ProdPW-1:0]   mcp_reg, prodp_reg;
    logic [EnergyW-1:0]  mlp_reg;
    logic [ProdSW-1:0]   mcs_reg, prods_reg;
    logic [DotW-1:0]     mls_reg;
    logic [RemW-1:0]     rem_reg, div_reg;
    logic [QuotW-1:0]    op_reg, res_reg, one_reg;
    logic [MagW-1:0]     mag_reg;
    logic                degen_reg;
    logic                out_valid_reg;
    logic signed [15:0]  cosine_reg;
    logic                degen_out_reg;

    logic [DotW-1:0]     dmag;
    logic [QuotW-1:0]    trial;
    logic [QuotW:0]      kk;
    logic [MagW-1:0]     mag_sq;
    logic                out_free;

    assign dmag     = q_data.dot[DotW-1] ? DotW'(-q_data.dot) : DotW'(q_data.dot);
    assign trial    = res_reg + one_reg;
    assign kk       = ({1'b0, res_reg} + (QuotW+1)'(1)) >> 1;
    assign mag_sq   = (kk > (QuotW+1)'(MagOne)) ? MagOne : kk[MagW-1:0];
    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == ST_IDLE) && !q_empty;

    assign out_valid  = out_valid_reg;
    assign cosine     = cosine_reg;
    assign degenerate = degen_out_reg;

    always_ff @(posedge clk) begin
        case (state_reg)
            ST_IDLE:
            begin
                neg_reg   <= q_data.dot[DotW-1];
                mcp_reg   <= ProdPW'(q_data.e1);
                mlp_reg   <= q_data.e2;
                mcs_reg   <= ProdSW'(dmag);
                mls_reg   <= dmag;
                prodp_reg <= '0;
                prods_reg <= '0;
                mag_reg   <= '0;
                degen_reg <= (q_data.e1 == '0) || (q_data.e2 == '0);
            end
            ST_MUL:
            begin
                if (mlp_reg[0])
                begin
                    prodp_reg <= prodp_reg + mcp_reg;
                end
                if (mls_reg[0])
                begin
                    prods_reg <= prods_reg + mcs_reg;
                end
                mcp_reg <= mcp_reg << 1;
                mlp_reg <= mlp_reg >> 1;
                mcs_reg <= mcs_reg << 1;
                mls_reg <= mls_reg >> 1;
                rem_reg <= RemW'({prods_reg, 32'd0});
                div_reg <= RemW'({prodp_reg, 33'd0});
                op_reg  <= '0;
                if (cnt_reg == 6'(DotW - 1))
                begin
                    rem_reg <= RemW'({(mls_reg[0] ? prods_reg + mcs_reg : prods_reg), 32'd0});
                    div_reg <= RemW'({(mlp_reg[0] ? prodp_reg + mcp_reg : prodp_reg), 33'd0});
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == 6'd0 && rem_reg >= (div_reg << 1))
                begin
                    // quotient beyond range: result saturates at one
                    mag_reg <= MagOne;
                end
                else if (rem_reg >= div_reg)
                begin
                    rem_reg <= rem_reg - div_reg;
                    op_reg  <= {op_reg[QuotW-2:0], 1'b1};
                end
                else
                begin
                    op_reg  <= {op_reg[QuotW-2:0], 1'b0};
                end
                div_reg <= div_reg >> 1;
                res_reg <= '0;
                one_reg <= QuotW'(1) << 32;
            end
            ST_SQRT:
            begin
                // root finished: latch the rounded magnitude
                if (cnt_reg == 6'(QuotW / 2))
                begin
                    mag_reg <= mag_sq;
                end
                else if (op_reg >= trial)
                begin
                    op_reg  <= op_reg - trial;
                    res_reg <= (res_reg >> 1) + one_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                one_reg <= one_reg >> 2;
            end
            ST_FIN:
            begin
            end
            default:
            begin
            end
        endcase
        if (state_reg == ST_FIN && out_free)
        begin
            degen_out_reg <= degen_reg;
            if (degen_reg)
            begin
                cosine_reg <= '0;
            end
            else if (neg_reg)
            begin
                cosine_reg <= 16'(-mag_reg);
            end
            else
            begin
                cosine_reg <= (mag_reg > MagW'(32767)) ? 16'sd32767 : 16'(mag_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (!q_empty)
                    begin
                        state_reg <= ((q_data.e1 == '0) || (q_data.e2 == '0)) ? ST_FIN : ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(DotW - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd0 && rem_reg >= (div_reg << 1))
                    begin
                        state_reg <= ST_FIN;
                    end
                    else if (cnt_reg == 6'(QuotW - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(QuotW / 2))
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: hdl/cosine_similarity_accumulator.sv
// Cosine similarity accumulator: one element pair per item, Q1.15 inputs.
// The front takes one pair every cycle unless in_stall is high, and accumulates in
// saturating 47-bit energy sums and a 48-bit dot sum; on the last pair the sums
// move through a two-entry queue to the back, which takes one set at a time through
// the shift-add multiplier pair, the restoring divider, the bit-wise root and
// rounding, and the hand-over, so short vectors throttle the front once the queue
// holds two sets.
// Depends on csa_pkg, csa_front, csa_queue, csa_back.
module cosine_similarity_accumulator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] first_value,
    input  logic signed [15:0] second_value,
    input  logic               last_pair,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] cosine,
    output logic               degenerate
);
    import csa_pkg::*;

    logic       push, pop, q_full, q_empty;
    csa_entry_t push_data, pop_data;

    assign in_stall = q_full;

    csa_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .q_full       (q_full),
        .first_value  (first_value),
        .second_value (second_value),
        .last_pair    (last_pair),
        .push         (push),
        .push_data    (push_data)
    );

    csa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    csa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (pop_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cosine     (cosine),
        .degenerate (degenerate)
    );
endmodule

FILE: hdl/csa_checker.sv
// Port-level checks for the cosine similarity accumulator, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module csa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        last_pair,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] cosine,
    input logic        degenerate
);
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped")
    `ASSERT_CLK(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(cosine), "result changed")
    `ASSERT_IMPL(a_degen_zero, clk, rst_n, out_valid && degenerate, cosine == 16'd0, "degenerate cosine")
    `ASSERT_CLK(a_stall_rise, clk, rst_n, $rose(in_stall) |-> $past(in_valid && last_pair), "stall rise")
endmodule

bind cosine_similarity_accumulator csa_checker u_csa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .last_pair  (last_pair),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cosine     (cosine),
    .degenerate (degenerate)
);
